FILE: sv/point_rotate_about_pivot_assert.svh
// ----------------------------------------------------------------------------
// Point rotation assertion macros
// Shared concurrent assertion forms used by the rotation block.
// ----------------------------------------------------------------------------
`ifndef POINT_ROTATE_ABOUT_PIVOT_ASSERT_SVH
`define POINT_ROTATE_ABOUT_PIVOT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRAP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("point rotation assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PRAP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("point rotation assertion failed");

`endif

FILE: sv/prap_pkg.sv
// ----------------------------------------------------------------------------
// Point rotation package
// Widths, defaults, the CORDIC arctangent table and the carried geometry type.
// ----------------------------------------------------------------------------
package prap_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int FRAC_BITS_DEF    = 15;
	localparam int MAX_STEPS        = 24;

	localparam int COORD_W = 16;
	localparam int ANGLE_W = 16;
	localparam int DIFF_W  = COORD_W + 1;
	// Angle accumulator: 2^32 units per turn plus headroom for the sweep.
	localparam int ZW      = 34;

	localparam logic [COORD_W-1:0] COORD_ONE = 16'd32768;
	localparam logic [ANGLE_W-1:0] QUARTER   = 16'd16384;
	localparam logic [63:0]        GAIN_Q30  = 64'd652032874;

	localparam logic [31:0] ATAN_TAB [0:MAX_STEPS-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// Offset from the pivot (already negated for a folded angle) and the pivot.
	typedef struct packed {
		logic signed [DIFF_W-1:0]  dx;
		logic signed [DIFF_W-1:0]  dy;
		logic        [COORD_W-1:0] qu;
		logic        [COORD_W-1:0] qv;
	} prap_geo_t;

endpackage

FILE: sv/point_rotate_about_pivot.sv
// ----------------------------------------------------------------------------
// Point rotation about a pivot
// Rotates a Q1.15 point about a Q1.15 pivot by a binary angle with a
// pipelined CORDIC and clamps the result to the unit square.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) carries a point, a pivot and a
// 16-bit binary angle (65536 is one full turn). The output channel
// (out_valid, out_stall) returns the rotated point, each coordinate clamped
// to 0..32768. A transaction completes on a rising clock edge where valid is
// high and stall is low. Every input transaction yields exactly one output
// transaction, in order.
// The stages, in order, fold the angle and form the offsets, run the
// CORDIC iterations, then form the products, the rounded sums and the
// clamp. Throughput is one transaction per cycle while the receiver does
// not stall; every CORDIC iteration has its own pipeline stage, so the
// stage count sets the latency only. When the receiver stalls, the
// output register holds its result and the stages behind it keep
// filling empty slots; in_stall rises only once every stage holds a
// transaction. Reset empties the pipeline; no output follows until new
// input arrives.
module point_rotate_about_pivot #(
	parameter int CORDIC_STEPS = prap_pkg::CORDIC_STEPS_DEF,
	parameter int FRAC_BITS    = prap_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [prap_pkg::COORD_W-1:0] point_u,
	input  logic [prap_pkg::COORD_W-1:0] point_v,
	input  logic [prap_pkg::ANGLE_W-1:0] turn_angle,
	input  logic [prap_pkg::COORD_W-1:0] pivot_u,
	input  logic [prap_pkg::COORD_W-1:0] pivot_v,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [prap_pkg::COORD_W-1:0] rotated_u,
	output logic [prap_pkg::COORD_W-1:0] rotated_v
);
	import prap_pkg::*;

	`include "point_rotate_about_pivot_assert.svh"

	localparam int XW = FRAC_BITS + 3;
	localparam int PW = DIFF_W + XW;
	localparam int SW = PW + 1;
	localparam int RW = SW - FRAC_BITS;
	localparam int FW = RW + 1;

	localparam logic signed [XW-1:0] X0 =
		XW'((GAIN_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
	localparam logic signed [SW-1:0] HALF = SW'(64'd1 << (FRAC_BITS - 1));

	// ---------------- Ready chain ----------------
	logic                  v_s1, v_s3, v_s4, v_s5;
	logic [CORDIC_STEPS-1:0] v_s2;
	logic                  rdy_s1, rdy_s3, rdy_s4, rdy_s5;
	logic [CORDIC_STEPS-1:0] rdy_s2;

	assign rdy_s5 = !v_s5 || !out_stall;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2[CORDIC_STEPS-1] = !v_s2[CORDIC_STEPS-1] || rdy_s3;
	for (genvar k = 0; k < CORDIC_STEPS - 1; k++) begin : g_rdy
		assign rdy_s2[k] = !v_s2[k] || rdy_s2[k+1];
	end
	assign rdy_s1   = !v_s1 || rdy_s2[0];
	assign in_stall = !rdy_s1;

	// ---------------- Stage 1: fold angle, form offsets ----------------
	logic signed [ANGLE_W:0]  ang;
	logic signed [ANGLE_W:0]  ang_fold;
	logic                     flip;
	logic signed [DIFF_W-1:0] du, dv;
	prap_geo_t                geo_s1;
	logic signed [ZW-1:0]     z_s1;

	always_comb begin
		ang = {turn_angle[ANGLE_W-1], turn_angle};
		flip = 1'b0;
		ang_fold = ang;
		if (ang > $signed({1'b0, QUARTER})) begin
			ang_fold = ang - $signed({1'b0, 1'b1, {(ANGLE_W-1){1'b0}}});
			flip = 1'b1;
		end else if (ang < -$signed({1'b0, QUARTER})) begin
			ang_fold = ang + $signed({1'b0, 1'b1, {(ANGLE_W-1){1'b0}}});
			flip = 1'b1;
		end
		du = $signed({1'b0, point_u}) - $signed({1'b0, pivot_u});
		dv = $signed({1'b0, point_v}) - $signed({1'b0, pivot_v});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	// Negating the offset is the same as negating cosine and sine afterwards.
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			geo_s1.dx <= flip ? -du : du;
			geo_s1.dy <= flip ? -dv : dv;
			geo_s1.qu <= pivot_u;
			geo_s1.qv <= pivot_v;
			z_s1      <= {{(ZW-ANGLE_W-17){ang_fold[ANGLE_W]}}, ang_fold, 16'b0};
		end
	end

	// ---------------- Stage 2: one CORDIC iteration per stage ----------------
	logic signed [XW-1:0] x_s2 [CORDIC_STEPS];
	logic signed [XW-1:0] y_s2 [CORDIC_STEPS];
	logic signed [ZW-1:0] z_s2 [CORDIC_STEPS];
	prap_geo_t            geo_s2 [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [XW-1:0] x_in, y_in;
		logic signed [ZW-1:0] z_in;
		prap_geo_t            geo_in;
		logic                 v_in, adv;
		logic signed [ZW-1:0] atan_i;

		if (i == 0) begin : g_first
			assign x_in   = X0;
			assign y_in   = '0;
			assign z_in   = z_s1;
			assign geo_in = geo_s1;
			assign v_in   = v_s1;
			assign adv    = rdy_s2[0];
		end else begin : g_next
			assign x_in   = x_s2[i-1];
			assign y_in   = y_s2[i-1];
			assign z_in   = z_s2[i-1];
			assign geo_in = geo_s2[i-1];
			assign v_in   = v_s2[i-1];
			assign adv    = rdy_s2[i];
		end

		assign atan_i = $signed({{(ZW-32){1'b0}}, ATAN_TAB[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s2[i] <= 1'b0;
			end else if (adv) begin
				v_s2[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv && v_in) begin
				if (!z_in[ZW-1]) begin
					x_s2[i] <= x_in - (y_in >>> i);
					y_s2[i] <= y_in + (x_in >>> i);
					z_s2[i] <= z_in - atan_i;
				end else begin
					x_s2[i] <= x_in + (y_in >>> i);
					y_s2[i] <= y_in - (x_in >>> i);
					z_s2[i] <= z_in + atan_i;
				end
				geo_s2[i] <= geo_in;
			end
		end
	end

	// ---------------- Stage 3: products ----------------
	logic signed [PW-1:0] pxc_s3, pys_s3, pxs_s3, pyc_s3;
	prap_geo_t            geo_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2[CORDIC_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2[CORDIC_STEPS-1]) begin
			pxc_s3 <= geo_s2[CORDIC_STEPS-1].dx * x_s2[CORDIC_STEPS-1];
			pys_s3 <= geo_s2[CORDIC_STEPS-1].dy * y_s2[CORDIC_STEPS-1];
			pxs_s3 <= geo_s2[CORDIC_STEPS-1].dx * y_s2[CORDIC_STEPS-1];
			pyc_s3 <= geo_s2[CORDIC_STEPS-1].dy * x_s2[CORDIC_STEPS-1];
			geo_s3 <= geo_s2[CORDIC_STEPS-1];
		end
	end

	// ---------------- Stage 4: sums, rounded half up ----------------
	logic signed [SW-1:0] sum_u, sum_v;
	logic signed [RW-1:0] ru_s4, rv_s4;
	prap_geo_t            geo_s4;

	assign sum_u = SW'(pxc_s3) - SW'(pys_s3) + HALF;
	assign sum_v = SW'(pxs_s3) + SW'(pyc_s3) + HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= v_s3;
		end
	end

	// Taking the upper bits is an arithmetic shift right by FRAC_BITS.
	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			ru_s4  <= sum_u[SW-1:FRAC_BITS];
			rv_s4  <= sum_v[SW-1:FRAC_BITS];
			geo_s4 <= geo_s3;
		end
	end

	// ---------------- Stage 5: add pivot back and clamp ----------------
	logic signed [FW-1:0]  fu, fv;
	logic [COORD_W-1:0]    cu, cv;
	logic [COORD_W-1:0]    ou_s5, ov_s5;

	always_comb begin
		fu = {ru_s4[RW-1], ru_s4} + $signed({{(FW-COORD_W){1'b0}}, geo_s4.qu});
		fv = {rv_s4[RW-1], rv_s4} + $signed({{(FW-COORD_W){1'b0}}, geo_s4.qv});
		if (fu[FW-1]) begin
			cu = '0;
		end else if (fu > $signed({{(FW-COORD_W){1'b0}}, COORD_ONE})) begin
			cu = COORD_ONE;
		end else begin
			cu = fu[COORD_W-1:0];
		end
		if (fv[FW-1]) begin
			cv = '0;
		end else if (fv > $signed({{(FW-COORD_W){1'b0}}, COORD_ONE})) begin
			cv = COORD_ONE;
		end else begin
			cv = fv[COORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (rdy_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			ou_s5 <= cu;
			ov_s5 <= cv;
		end
	end

	assign out_valid = v_s5;
	assign rotated_u = ou_s5;
	assign rotated_v = ov_s5;

	// ---------------- Assertions ----------------
	`PRAP_ASSERT_NOW(a_out_u_in_range, clk, arst_n, out_valid, rotated_u <= COORD_ONE)
	`PRAP_ASSERT_NOW(a_out_v_in_range, clk, arst_n, out_valid, rotated_v <= COORD_ONE)
	`PRAP_ASSERT_NOW(a_stall_only_when_full, clk, arst_n, in_stall, out_valid && out_stall)
	`PRAP_ASSERT_NEXT(a_accept_enters, clk, arst_n, in_valid && !in_stall, v_s1)

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Point rotation about a pivot: testbench
// Drives points, pivots and binary angles into the rotation pipeline and
// checks every rotated, clamped point against a CORDIC predictor kept here.
// The sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import prap_pkg::*;

	localparam int STEPS        = CORDIC_STEPS_DEF;
	localparam int FRAC         = FRAC_BITS_DEF;
	localparam int DRAIN_CYCLES = STEPS + 4 + 20;

	typedef struct {
		logic [COORD_W-1:0] u;
		logic [COORD_W-1:0] v;
	} rot_point_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [COORD_W-1:0] point_u;
	logic [COORD_W-1:0] point_v;
	logic [ANGLE_W-1:0] turn_angle;
	logic [COORD_W-1:0] pivot_u;
	logic [COORD_W-1:0] pivot_v;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [COORD_W-1:0] rotated_u;
	logic [COORD_W-1:0] rotated_v;

	rot_point_t rotated_due[$];
	rot_point_t oldest;
	int         fails = 0;
	int         points_sent = 0;
	int         points_checked = 0;
	int         burst_left = 0;
	bit         gaps_on = 1'b1;
	bit         rx_quiet = 1'b0;
	int         stall_run = 0;
	logic [31:0] rx_cycle = '0;

	point_rotate_about_pivot #(
		.CORDIC_STEPS(STEPS),
		.FRAC_BITS   (FRAC)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.point_u   (point_u),
		.point_v   (point_v),
		.turn_angle(turn_angle),
		.pivot_u   (pivot_u),
		.pivot_v   (pivot_v),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.rotated_u (rotated_u),
		.rotated_v (rotated_v)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Rounds a product back to Q1.15, adds the pivot and clamps to 0..1.0.
	function automatic logic [COORD_W-1:0] round_and_clamp(input longint prod,
			input logic [COORD_W-1:0] pivot);
		longint v;
		v = ((prod + (longint'(1) << (FRAC - 1))) >>> FRAC) + longint'(pivot);
		if (v < 0)
			v = 0;
		if (v > longint'(COORD_ONE))
			v = longint'(COORD_ONE);
		return v[COORD_W-1:0];
	endfunction

	function automatic rot_point_t rotate_about_pivot(input logic [COORD_W-1:0] pu,
			input logic [COORD_W-1:0] pv, input logic [ANGLE_W-1:0] ang,
			input logic [COORD_W-1:0] qu, input logic [COORD_W-1:0] qv);
		longint     a, x, y, z, xs, ys, dx, dy, step_ang;
		bit         flip;
		int         i;
		rot_point_t r;
		a = longint'(ang);
		flip = 1'b0;
		if (a >= 32768)
			a -= 65536;
		// Angles beyond a quarter turn are folded by half a turn and the
		// sine and cosine negated afterward.
		if (a > 16384) begin
			a -= 32768;
			flip = 1'b1;
		end else if (a < -16384) begin
			a += 32768;
			flip = 1'b1;
		end
		z = a * 65536;
		x = (longint'(GAIN_Q30) + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
		y = 0;
		for (i = 0; i < STEPS && i < MAX_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			step_ang = longint'(ATAN_TAB[i]);
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - step_ang;
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + step_ang;
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		dx = longint'(pu) - longint'(qu);
		dy = longint'(pv) - longint'(qv);
		r.u = round_and_clamp(dx * x - dy * y, qu);
		r.v = round_and_clamp(dx * y + dy * x, qv);
		return r;
	endfunction

	// Offers one point and returns once the transaction has been accepted.
	task automatic send_point(input logic [COORD_W-1:0] pu, input logic [COORD_W-1:0] pv,
			input logic [ANGLE_W-1:0] ang, input logic [COORD_W-1:0] qu,
			input logic [COORD_W-1:0] qv);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 12);
			burst_left = $urandom_range(1, 16);
			@(negedge clk);
			in_valid   <= 1'b0;
			point_u    <= 16'($urandom);
			point_v    <= 16'($urandom);
			turn_angle <= 16'($urandom);
			pivot_u    <= 16'($urandom);
			pivot_v    <= 16'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		point_u    <= pu;
		point_v    <= pv;
		turn_angle <= ang;
		pivot_u    <= qu;
		pivot_v    <= qv;
		do
			@(posedge clk);
		while (in_stall);
		rotated_due.push_back(rotate_about_pivot(pu, pv, ang, qu, qv));
		points_sent++;
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (rotated_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [COORD_W-1:0] random_coord();
		if ($urandom_range(0, 6) == 0)
			return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, 32768));
	endfunction

	function automatic logic [ANGLE_W-1:0] random_angle();
		if ($urandom_range(0, 9) == 0)
			return 16'(QUARTER * $urandom_range(0, 3)) + 16'($urandom_range(0, 2)) - 16'd1;
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic test_field_extremes();
		send_point(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_point(16'd32768, 16'd32768, 16'd0, 16'd32768, 16'd32768);
		send_point(16'd32768, 16'd0, 16'd16384, 16'd0, 16'd0);
		send_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_point(16'hFFFF, 16'd0, 16'd8192, 16'd0, 16'hFFFF);
		send_point(16'd0, 16'hFFFF, 16'd40000, 16'd32768, 16'd0);
		send_point(16'd16384, 16'd16384, 16'd12345, 16'd16384, 16'd16384);
	endtask

	// Angles on both sides of each fold boundary.
	task automatic test_angle_folding();
		logic [ANGLE_W-1:0] angles[10];
		angles = '{16'd0, 16'd16383, 16'd16384, 16'd16385, 16'd32767,
			16'd32768, 16'd49151, 16'd49152, 16'd49153, 16'd65535};
		foreach (angles[k])
			send_point(16'd24576, 16'd16384, angles[k], 16'd16384, 16'd16384);
	endtask

	task automatic test_clamping();
		send_point(16'd32768, 16'd32768, 16'd16384, 16'd0, 16'd0);
		send_point(16'd0, 16'd0, 16'd32768, 16'd32768, 16'd32768);
		send_point(16'd32768, 16'd0, 16'd49152, 16'd0, 16'd32768);
		send_point(16'd0, 16'd32768, 16'd8192, 16'd32768, 16'd0);
	endtask

	// Full rate on both sides, then gaps and stalls; drains once midway.
	task automatic test_random_rotations(input int count);
		int n;
		gaps_on = 1'b0;
		rx_quiet = 1'b1;
		for (n = 0; n < count; n++) begin
			if (n == count / 5) begin
				gaps_on = 1'b1;
				rx_quiet = 1'b0;
			end
			if (n == count / 2)
				wait_all_results();
			send_point(random_coord(), random_coord(), random_angle(),
				random_coord(), random_coord());
		end
	endtask

	// The receiver cycles through no stall, light, bursty and heavy stalling.
	always @(negedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_quiet) begin
			out_stall <= 1'b0;
		end else begin
			case (rx_cycle[8:7])
				2'd0: out_stall <= 1'b0;
				2'd1: out_stall <= ($urandom_range(0, 2) == 0);
				2'd2: begin
					if (stall_run > 0) begin
						stall_run--;
						out_stall <= 1'b1;
					end else if ($urandom_range(0, 15) == 0) begin
						stall_run = $urandom_range(1, 40);
						out_stall <= 1'b1;
					end else begin
						out_stall <= 1'b0;
					end
				end
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (rotated_due.size() == 0) begin
				$error("unexpected rotated point: u=%0d v=%0d", rotated_u, rotated_v);
				fails++;
			end else begin
				oldest = rotated_due.pop_front();
				points_checked++;
				if (rotated_u !== oldest.u) begin
					$error("rotated_u mismatch: expected %0d, actual %0d", oldest.u, rotated_u);
					fails++;
				end
				if (rotated_v !== oldest.v) begin
					$error("rotated_v mismatch: expected %0d, actual %0d", oldest.v, rotated_v);
					fails++;
				end
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		point_u    = '0;
		point_v    = '0;
		turn_angle = '0;
		pivot_u    = '0;
		pivot_v    = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_field_extremes();
		test_angle_folding();
		test_clamping();
		test_random_rotations(500);

		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d transactions in, %0d rotated points checked, with fold",
			points_sent, points_checked);
		$display("boundaries, clamping, out-of-range inputs, full rate and stalls.");
		if (fails == 0)
			$display("point_rotate_about_pivot regression: pass");
		else
			$display("point_rotate_about_pivot regression: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timed out waiting for rotated points.");
		$display("point_rotate_about_pivot regression: fail");
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/prap_pkg.sv
sv/point_rotate_about_pivot.sv
tb/tb.sv
